// ----- src/source_map_mapping_decoder_macros.svh -----
// Assertion helpers shared by the decoder modules.
// Each check is sampled at the rising clock edge and is off during reset.
`ifndef SOURCE_MAP_MAPPING_DECODER_MACROS_SVH
`define SOURCE_MAP_MAPPING_DECODER_MACROS_SVH

// Same-cycle implication.
`define SMD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed");

// Next-cycle implication.
`define SMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

// ----- src/smd_pkg.sv -----
`timescale 1ns / 1ps

package smd_pkg;

  // Character codes that steer the decoder.
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Digit format: five payload bits and one continuation flag.
  localparam int unsigned DIGIT_BITS = 5;
  localparam int unsigned CONT_BIT   = 5;

  // Segment value slots and the value counter limit.
  localparam logic [7:0] SLOT_COLUMN      = 8'd0;
  localparam logic [7:0] SLOT_SOURCE      = 8'd1;
  localparam logic [7:0] SLOT_ORIG_LINE   = 8'd2;
  localparam logic [7:0] SLOT_ORIG_COLUMN = 8'd3;
  localparam logic [7:0] COUNT_MAX        = 8'd255;

  // Classified character, handed from the decoder to the state logic.
  typedef struct packed {
    logic       is_sep;
    logic       is_semi;
    logic       cont;
    logic [4:0] digit_bits;
    logic       eot;
  } char_class_t;

  // One emitted segment.
  typedef struct packed {
    logic        [31:0] gen_line;
    logic signed [31:0] gen_column;
    logic signed [31:0] source_index;
    logic signed [31:0] orig_line;
    logic signed [31:0] orig_column;
    logic        [7:0]  value_count;
    logic               closes_line;
    logic               final_segment;
  } result_t;

  // Base64 digit value: 0..63 for digits, 64 for '=', 0 for anything else.
  function automatic logic [6:0] b64_digit(input logic [7:0] c);
    logic [6:0] d;
    d = 7'd0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      d = 7'(c - CHAR_UP_A);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      d = 7'(c - CHAR_LO_A) + 7'd26;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = 7'(c - CHAR_ZERO) + 7'd52;
    end else if (c == CHAR_PLUS) begin
      d = 7'd62;
    end else if (c == CHAR_SLASH) begin
      d = 7'd63;
    end else if (c == CHAR_EQUALS) begin
      d = 7'd64;
    end
    return d;
  endfunction

endpackage

// ----- src/smd_if.sv -----
`timescale 1ns / 1ps

// Character stream channel.
interface smd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// Decoded segment channel.
interface smd_seg_if;
  logic               valid;
  logic               ready;
  logic        [31:0] gen_line;
  logic signed [31:0] gen_column;
  logic signed [31:0] source_index;
  logic signed [31:0] orig_line;
  logic signed [31:0] orig_column;
  logic        [7:0]  value_count;
  logic               closes_line;
  logic               final_segment;

  modport source (
    output valid, output gen_line, output gen_column, output source_index,
    output orig_line, output orig_column, output value_count,
    output closes_line, output final_segment, input ready
  );
  modport sink (
    input valid, input gen_line, input gen_column, input source_index,
    input orig_line, input orig_column, input value_count,
    input closes_line, input final_segment, output ready
  );
endinterface

// ----- src/source_map_mapping_decoder.sv -----
`timescale 1ns / 1ps
// A closing character is captured in the input register, then its segment in the result register.
// Throughput: one character per cycle unless a held result stalls the input; the input and result
// registers are separated by table lookup, digit placement and one add/subtract.
// Reset: synchronous, active high; clears all sums, the line count and both valid flags.
`include "source_map_mapping_decoder_macros.svh"

module source_map_mapping_decoder #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  smd_char_if.sink    chars,
  smd_seg_if.source   segments
);

  logic                 s1_valid;
  logic [7:0]           s1_char;
  logic                 s1_eot;
  logic                 s1_advance;
  smd_pkg::char_class_t cls;
  logic                 emit;
  smd_pkg::result_t     res;
  logic                 out_valid;
  smd_pkg::result_t     out_res;

  // The character stage moves on whenever the result register has room.
  assign s1_advance  = s1_valid && (!out_valid || segments.ready);
  assign chars.ready = !s1_valid || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
    if (chars.valid && chars.ready) begin
      s1_char <= chars.char_code;
      s1_eot  <= chars.end_of_text;
    end
  end

  smd_char_decode u_decode (
    .char_code   (s1_char),
    .end_of_text (s1_eot),
    .cls         (cls)
  );

  smd_state #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .cls     (cls),
    .emit    (emit),
    .res     (res)
  );

  // Result register; holds a transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= emit;
    end else if (segments.ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_res <= res;
    end
  end

  assign segments.valid         = out_valid;
  assign segments.gen_line      = out_res.gen_line;
  assign segments.gen_column    = out_res.gen_column;
  assign segments.source_index  = out_res.source_index;
  assign segments.orig_line     = out_res.orig_line;
  assign segments.orig_column   = out_res.orig_column;
  assign segments.value_count   = out_res.value_count;
  assign segments.closes_line   = out_res.closes_line;
  assign segments.final_segment = out_res.final_segment;

  // Only segments holding a value are ever presented.
  `SMD_ASSERT_IMPL(a_result_nonempty, out_valid, out_res.value_count != 8'd0)
  // A stalled character keeps its place and contents.
  `SMD_ASSERT_NEXT(a_stage_holds, s1_valid && !s1_advance, s1_valid && $stable(s1_char) && $stable(s1_eot))
  // A waiting result is not overwritten.
  `SMD_ASSERT_NEXT(a_result_holds, out_valid && !segments.ready, out_valid && $stable(out_res))

endmodule

// ----- src/smd_char_decode.sv -----
`timescale 1ns / 1ps

// Sorts one character into separator or digit and extracts its digit bits.
module smd_char_decode (
  input  logic [7:0]          char_code,
  input  logic                end_of_text,
  output smd_pkg::char_class_t cls
);

  logic [6:0] digit;

  // Table lookup; '=' yields zero payload bits and no continuation.
  assign digit = smd_pkg::b64_digit(char_code);

  always_comb begin
    cls.is_semi    = (char_code == smd_pkg::CHAR_SEMI);
    cls.is_sep     = (char_code == smd_pkg::CHAR_SEMI) || (char_code == smd_pkg::CHAR_COMMA);
    cls.cont       = digit[smd_pkg::CONT_BIT];
    cls.digit_bits = digit[smd_pkg::DIGIT_BITS-1:0];
    cls.eot        = end_of_text;
  end

endmodule

// ----- src/smd_state.sv -----
`timescale 1ns / 1ps
`include "source_map_mapping_decoder_macros.svh"

// Value accumulator and running position sums; updates once per character.
module smd_state #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  smd_pkg::char_class_t cls,
  output logic                 emit,
  output smd_pkg::result_t     res
);

  localparam int unsigned SHW   = $clog2(VALUE_WIDTH + smd_pkg::DIGIT_BITS);
  localparam int unsigned EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic [SHW-1:0]         shift, shift_next;
  logic [7:0]             values, values_next;
  logic [VALUE_WIDTH-1:0] line, line_next;
  logic [VALUE_WIDTH-1:0] column, column_next;
  logic [VALUE_WIDTH-1:0] source, source_next;
  logic [VALUE_WIDTH-1:0] orig_line, orig_line_next;
  logic [VALUE_WIDTH-1:0] orig_column, orig_column_next;

  logic                   shift_ok;
  logic [VALUE_WIDTH-1:0] placed;
  logic [VALUE_WIDTH-1:0] acc_full;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   value_done;
  logic [VALUE_WIDTH-1:0] operand;
  logic [VALUE_WIDTH-1:0] updated;
  logic [7:0]             values_after;
  logic [VALUE_WIDTH-1:0] column_after;
  logic [VALUE_WIDTH-1:0] source_after;
  logic [VALUE_WIDTH-1:0] orig_line_after;
  logic [VALUE_WIDTH-1:0] orig_column_after;
  logic [SHW-1:0]         shift_inc;

  // Zero-extend or truncate a sum to the 32-bit result field.
  function automatic logic [31:0] to_field(input logic [VALUE_WIDTH-1:0] x);
    logic [EXT_W-1:0] wide;
    wide = EXT_W'(x);
    return wide[31:0];
  endfunction

  // Place the digit; earlier digits sit below the shift, so OR is the sum.
  assign shift_ok   = (shift < SHW'(VALUE_WIDTH));
  assign placed     = VALUE_WIDTH'(cls.digit_bits) << shift;
  assign acc_full   = shift_ok ? (acc | placed) : acc;
  assign value_done = !cls.is_sep && !cls.cont;
  assign mag        = acc_full >> 1;

  // One shared add/subtract applies the sign-decoded value to its slot.
  always_comb begin
    case (values)
      smd_pkg::SLOT_COLUMN:      operand = column;
      smd_pkg::SLOT_SOURCE:      operand = source;
      smd_pkg::SLOT_ORIG_LINE:   operand = orig_line;
      smd_pkg::SLOT_ORIG_COLUMN: operand = orig_column;
      default:                   operand = column;
    endcase
    updated = acc_full[0] ? (operand - mag) : (operand + mag);
  end

  always_comb begin
    column_after      = column;
    source_after      = source;
    orig_line_after   = orig_line;
    orig_column_after = orig_column;
    values_after      = values;
    if (value_done) begin
      case (values)
        smd_pkg::SLOT_COLUMN:      column_after      = updated;
        smd_pkg::SLOT_SOURCE:      source_after      = updated;
        smd_pkg::SLOT_ORIG_LINE:   orig_line_after   = updated;
        smd_pkg::SLOT_ORIG_COLUMN: orig_column_after = updated;
        default:                   ;
      endcase
      if (values != smd_pkg::COUNT_MAX) begin
        values_after = values + 8'd1;
      end
    end
  end

  // Saturating digit position.
  assign shift_inc = (shift_ok) ? (shift + SHW'(smd_pkg::DIGIT_BITS)) : shift;

  // A segment end with at least one value produces a result.
  assign emit = advance && (cls.is_sep || cls.eot) && (values_after != 8'd0);

  always_comb begin
    res.gen_line      = to_field(line);
    res.gen_column    = to_field(column_after);
    res.source_index  = to_field(source_after);
    res.orig_line     = to_field(orig_line_after);
    res.orig_column   = to_field(orig_column_after);
    res.value_count   = values_after;
    res.closes_line   = cls.is_semi;
    res.final_segment = cls.eot;
  end

  // Next state; the last character of a text returns everything to zero.
  always_comb begin
    acc_next         = '0;
    shift_next       = '0;
    values_next      = '0;
    line_next        = line;
    column_next      = column_after;
    source_next      = source_after;
    orig_line_next   = orig_line_after;
    orig_column_next = orig_column_after;
    if (cls.eot) begin
      line_next        = '0;
      column_next      = '0;
      source_next      = '0;
      orig_line_next   = '0;
      orig_column_next = '0;
    end else if (cls.is_sep) begin
      if (cls.is_semi) begin
        line_next   = line + VALUE_WIDTH'(1);
        column_next = '0;
      end
    end else begin
      values_next = values_after;
      if (cls.cont) begin
        acc_next   = acc_full;
        shift_next = (shift_inc > SHW'(VALUE_WIDTH)) ? SHW'(VALUE_WIDTH) : shift_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      shift       <= '0;
      values      <= '0;
      line        <= '0;
      column      <= '0;
      source      <= '0;
      orig_line   <= '0;
      orig_column <= '0;
    end else if (advance) begin
      acc         <= acc_next;
      shift       <= shift_next;
      values      <= values_next;
      line        <= line_next;
      column      <= column_next;
      source      <= source_next;
      orig_line   <= orig_line_next;
      orig_column <= orig_column_next;
    end
  end

  // A finished text leaves the decoder ready for a fresh one.
  `SMD_ASSERT_NEXT(a_text_restart, advance && cls.eot, values == 8'd0 && line == '0 && shift == '0)
  // The digit position never passes the value width.
  `SMD_ASSERT_IMPL(a_shift_bound, 1'b1, shift <= SHW'(VALUE_WIDTH))
  // An emitted segment always carries at least one value.
  `SMD_ASSERT_IMPL(a_emit_counted, emit, res.value_count != 8'd0)

endmodule

// ----- sim/source_map_mapping_decoder_test.sv -----
`timescale 1ns / 1ps

module source_map_mapping_decoder_test;

  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned RANDOM_CHARS  = 950;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT    = 2000;

  // Follows the decoder state for every accepted character and queues the segments it owes.
  class segment_scoreboard;
    smd_pkg::result_t expected_segments[$];
    int unsigned      error_count;
    logic [31:0]      partial_value;
    int unsigned      bit_offset;
    logic [7:0]       seg_values;
    logic [31:0]      line_total;
    logic [31:0]      column_total;
    logic [31:0]      source_total;
    logic [31:0]      orig_line_total;
    logic [31:0]      orig_column_total;

    function new();
      error_count = 0;
      clear_text();
    endfunction

    // A finished text leaves every running position at zero.
    function void clear_text();
      partial_value     = '0;
      bit_offset        = 0;
      seg_values        = '0;
      line_total        = '0;
      column_total      = '0;
      source_total      = '0;
      orig_line_total   = '0;
      orig_column_total = '0;
    endfunction

    // Base64 digit value; the padding sign gives 64 and any stray byte gives 0.
    function logic [6:0] digit_of(logic [7:0] c);
      logic [6:0] d;
      d = 7'd0;
      if (c == smd_pkg::CHAR_EQUALS) begin
        d = 7'd64;
      end else if (c == smd_pkg::CHAR_SLASH) begin
        d = 7'd63;
      end else if (c == smd_pkg::CHAR_PLUS) begin
        d = 7'd62;
      end else if (c >= smd_pkg::CHAR_ZERO && c <= smd_pkg::CHAR_NINE) begin
        // Numerals start at digit 52, four above their code.
        d = 7'(c) + 7'd4;
      end else if (c >= smd_pkg::CHAR_LO_A && c <= smd_pkg::CHAR_LO_Z) begin
        d = 7'(c - smd_pkg::CHAR_LO_A) + 7'd26;
      end else if (c >= smd_pkg::CHAR_UP_A && c <= smd_pkg::CHAR_UP_Z) begin
        d = 7'(c - smd_pkg::CHAR_UP_A);
      end
      return d;
    endfunction

    // Sign-decode a finished value and add it to the sum of its slot.
    function void apply_value(logic [31:0] v);
      logic [31:0] mag;
      logic [31:0] delta;
      mag = v >> 1;
      delta = v[0] ? -mag : mag;
      case (seg_values)
        smd_pkg::SLOT_COLUMN:      column_total      += delta;
        smd_pkg::SLOT_SOURCE:      source_total      += delta;
        smd_pkg::SLOT_ORIG_LINE:   orig_line_total   += delta;
        smd_pkg::SLOT_ORIG_COLUMN: orig_column_total += delta;
        default: ;
      endcase
      if (seg_values != smd_pkg::COUNT_MAX) seg_values++;
    endfunction

    // Note one accepted character and queue the segment it closes, if any.
    function void take_char(logic [7:0] c, logic eot);
      logic [6:0]       d;
      logic             semi;
      logic             sep;
      smd_pkg::result_t seg;
      semi = (c == smd_pkg::CHAR_SEMI);
      sep  = semi || (c == smd_pkg::CHAR_COMMA);
      if (!sep) begin
        d = digit_of(c);
        if (bit_offset < VALUE_BITS) partial_value += 32'(d[4:0]) << bit_offset;
        if (d[smd_pkg::CONT_BIT]) begin
          bit_offset = (bit_offset + smd_pkg::DIGIT_BITS > VALUE_BITS) ? VALUE_BITS
                       : bit_offset + smd_pkg::DIGIT_BITS;
        end else begin
          apply_value(partial_value);
          partial_value = '0;
          bit_offset = 0;
        end
      end
      if (sep || eot) begin
        if (seg_values != 0) begin
          seg.gen_line      = line_total;
          seg.gen_column    = column_total;
          seg.source_index  = source_total;
          seg.orig_line     = orig_line_total;
          seg.orig_column   = orig_column_total;
          seg.value_count   = seg_values;
          seg.closes_line   = semi;
          seg.final_segment = eot;
          expected_segments.push_back(seg);
        end
        partial_value = '0;
        bit_offset = 0;
        seg_values = '0;
        if (semi) begin
          line_total++;
          column_total = '0;
        end
      end
      if (eot) clear_text();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
    endtask

    task compare_field(string name, logic [31:0] got_val, logic [31:0] want_val);
      if (got_val !== want_val) begin
        report_mismatch($sformatf("%s is %h, expected %h", name, got_val, want_val));
      end
    endtask

    // Compare one received segment with the oldest one owed.
    task check_segment(smd_pkg::result_t got);
      smd_pkg::result_t want;
      if (expected_segments.size() == 0) begin
        report_mismatch($sformatf("segment at line %0d column %0d arrived with none owed",
                                  got.gen_line, got.gen_column));
        return;
      end
      want = expected_segments.pop_front();
      compare_field("gen_line", got.gen_line, want.gen_line);
      compare_field("gen_column", got.gen_column, want.gen_column);
      compare_field("source_index", got.source_index, want.source_index);
      compare_field("orig_line", got.orig_line, want.orig_line);
      compare_field("orig_column", got.orig_column, want.orig_column);
      compare_field("value_count", 32'(got.value_count), 32'(want.value_count));
      compare_field("closes_line", 32'(got.closes_line), 32'(want.closes_line));
      compare_field("final_segment", 32'(got.final_segment), 32'(want.final_segment));
    endtask

    task close_out();
      if (expected_segments.size() != 0) begin
        report_mismatch($sformatf("%0d segments never arrived", expected_segments.size()));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  smd_char_if char_bus();
  smd_seg_if  seg_bus();

  source_map_mapping_decoder dut (
    .clk(clk),
    .rst(rst),
    .chars(char_bus),
    .segments(seg_bus)
  );

  segment_scoreboard board = new();
  int unsigned      char_idle_pct = 0;
  int unsigned      seg_stall_pct = 0;
  int unsigned      chars_sent = 0;
  int unsigned      quiet_cycles = 0;
  smd_pkg::result_t seg_seen;

  assign seg_seen = {seg_bus.gen_line, seg_bus.gen_column, seg_bus.source_index,
                     seg_bus.orig_line, seg_bus.orig_column, seg_bus.value_count,
                     seg_bus.closes_line, seg_bus.final_segment};

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Segment receiver: check each transaction, then decide whether to stall.
  always @(posedge clk) begin
    if (rst) begin
      seg_bus.ready <= 1'b0;
    end else begin
      if (seg_bus.valid && seg_bus.ready) board.check_segment(seg_seen);
      seg_bus.ready <= ($urandom_range(99) >= seg_stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((char_bus.valid && char_bus.ready) || (seg_bus.valid && seg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] b64_char(input int unsigned d);
    if (d < 26) return smd_pkg::CHAR_UP_A + 8'(d);
    if (d < 52) return smd_pkg::CHAR_LO_A + 8'(d - 26);
    if (d < 62) return smd_pkg::CHAR_ZERO + 8'(d - 52);
    return (d == 62) ? smd_pkg::CHAR_PLUS : smd_pkg::CHAR_SLASH;
  endfunction

  // Offer one character, idling first as the current phase asks.
  task automatic send_char(input logic [7:0] code, input logic last);
    while ($urandom_range(99) < char_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid       <= 1'b1;
    char_bus.char_code   <= code;
    char_bus.end_of_text <= last;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    board.take_char(code, last);
    chars_sent++;
  endtask

  // One value: a few continuation digits, then a closing digit, padding or stray byte.
  task automatic send_value(input logic last);
    int unsigned pick;
    int unsigned extra;
    logic [7:0]  term;
    pick = $urandom_range(99);
    if (pick < 55) begin
      extra = 0;
    end else if (pick < 85) begin
      extra = 1;
    end else if (pick < 95) begin
      extra = $urandom_range(3, 2);
    end else begin
      extra = $urandom_range(8, 4);
    end
    for (int i = 0; i < extra; i++) send_char(b64_char(32 + $urandom_range(31)), 1'b0);
    pick = $urandom_range(19);
    if (pick == 0) begin
      term = smd_pkg::CHAR_EQUALS;
    end else if (pick == 1) begin
      term = 8'($urandom_range(255, 128));
    end else begin
      term = b64_char($urandom_range(31));
    end
    send_char(term, last);
  endtask

  // A segment of values closed by a separator, by the end of the text, or both.
  task automatic send_segment(input int unsigned value_total);
    int unsigned pick;
    logic        text_ends;
    logic        sep_ends;
    logic [7:0]  sep;
    pick = $urandom_range(99);
    text_ends = (pick >= 88);
    sep_ends  = (pick < 88) || (pick >= 94) || (value_total == 0);
    sep = ($urandom_range(2) == 0) ? smd_pkg::CHAR_SEMI : smd_pkg::CHAR_COMMA;
    for (int i = 0; i < value_total; i++) begin
      send_value(text_ends && !sep_ends && (i == value_total - 1));
    end
    if (sep_ends) begin
      // Now and then leave a value unfinished so that the separator drops it.
      if ($urandom_range(9) == 0) send_char(b64_char(32 + $urandom_range(31)), 1'b0);
      send_char(sep, text_ends);
    end
  endtask

  // Wait with the input idle until every owed segment has come back.
  task automatic pause_until_drained();
    char_bus.valid <= 1'b0;
    while (board.expected_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase_end;
    int unsigned phase;
    int unsigned pick;
    logic        paused;
    logic        saturated;

    rst = 1'b1;
    char_bus.valid <= 1'b0;
    char_bus.char_code <= '0;
    char_bus.end_of_text <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty segments: a line break and a comma with nothing before them.
    send_char(smd_pkg::CHAR_SEMI, 1'b0);
    send_char(smd_pkg::CHAR_COMMA, 1'b0);
    // Five values with a negative one, padding and a stray byte; the fifth is ignored.
    send_char("D", 1'b0);
    send_char("g", 1'b0);
    send_char("B", 1'b0);
    send_char(smd_pkg::CHAR_EQUALS, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("a", 1'b0);
    send_char(smd_pkg::CHAR_COMMA, 1'b0);
    // A finished value followed by an unfinished one at a line break.
    send_char("K", 1'b0);
    send_char("z", 1'b0);
    send_char(smd_pkg::CHAR_SEMI, 1'b0);
    // A value long enough to run past the top of the accumulator.
    repeat (7) send_char(smd_pkg::CHAR_SLASH, 1'b0);
    send_char(smd_pkg::CHAR_PLUS, 1'b0);
    send_char("9", 1'b0);
    send_char("f", 1'b0);
    send_char(smd_pkg::CHAR_COMMA, 1'b0);
    // End of text on a line break, then a text of one digit.
    send_char("0", 1'b0);
    send_char("Z", 1'b0);
    send_char(smd_pkg::CHAR_SEMI, 1'b1);
    send_char("C", 1'b1);

    // Random texts, cycling through the idling phases.
    random_start = chars_sent;
    phase = 0;
    phase_end = chars_sent + $urandom_range(90, 40);
    paused = 1'b0;
    saturated = 1'b0;
    while (chars_sent < random_start + RANDOM_CHARS) begin
      if (chars_sent >= phase_end) begin
        phase = (phase + 1) % 4;
        case (phase)
          0: begin char_idle_pct = 0;  seg_stall_pct = 0;  end
          1: begin char_idle_pct = 66; seg_stall_pct = 0;  end
          2: begin char_idle_pct = 0;  seg_stall_pct = 66; end
          default: begin char_idle_pct = 12; seg_stall_pct = 12; end
        endcase
        phase_end = chars_sent + $urandom_range(90, 40);
      end
      if (!paused && chars_sent >= random_start + RANDOM_CHARS / 2) begin
        pause_until_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (!saturated && chars_sent >= random_start + RANDOM_CHARS / 3) begin
        // Enough values to pin the value count at its limit.
        send_segment(258);
        saturated = 1'b1;
      end else if (pick < 8) begin
        // Raw bytes of any code.
        repeat ($urandom_range(4, 1)) send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
      end else if (pick < 13) begin
        send_segment(0);
      end else if (pick < 90) begin
        send_segment($urandom_range(5, 1));
      end else if (pick < 99) begin
        send_segment($urandom_range(12, 6));
      end else begin
        send_segment($urandom_range(262, 250));
      end
    end

    // Let every owed segment arrive, then allow for any late extra one.
    char_bus.valid <= 1'b0;
    while (board.expected_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.close_out();
    if (board.error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
